// File: src/ipi_pkg.sv
// ----------------------------------------------------------------------------
// Image pixel interpolator package
// Shared types, constants and arithmetic helpers of the frame-store sampler.
// ----------------------------------------------------------------------------
package ipi_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 512;
   localparam int FRAC_BITS      = 8;

   localparam int COL_W  = 10;
   localparam int ROW_W  = 9;
   localparam int CH_W   = 8;
   localparam int SX_W   = 18;
   localparam int SY_W   = 17;
   localparam int XI_W   = SX_W - FRAC_BITS;
   localparam int WID_W  = 11;
   localparam int HGT_W  = 10;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 11;

   localparam int REM_W     = WID_W + 1;
   localparam int W_W       = FRAC_BITS + 2;
   localparam int WT_W      = 3 * FRAC_BITS + 4;
   localparam int ROWACC_W  = 20;
   localparam int ACC_W     = 32;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 24;

   localparam int COL_LSB   = 0;
   localparam int ROW_LSB   = COL_LSB + COL_W;
   localparam int BLUE_LSB  = ROW_LSB + ROW_W;
   localparam int GREEN_LSB = BLUE_LSB + CH_W;
   localparam int RED_LSB   = GREEN_LSB + CH_W;
   localparam int SX_LSB    = RED_LSB + CH_W;
   localparam int SY_LSB    = SX_LSB + SX_W;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd2;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      MODE_NEAREST,
      MODE_BILINEAR,
      MODE_BICUBIC,
      MODE_UNUSED
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_TAPS,
      ST_FETCH,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic       load;
      logic       mem_write;
      logic       clear_result;
      logic       mod_step;
      logic       taps_load;
      logic       fetch_en;
      logic [1:0] tap_col;
      logic [1:0] tap_row;
      logic       row_last;
      logic       last_tap;
      logic       result_load;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     res_ready;
      logic     slot_free;
   } status_type;

   // Kernel weight rounded half away from zero to FRAC_BITS fraction bits.
   function automatic logic signed [W_W-1:0] round_weight(input logic signed [WT_W-1:0] v);
      logic [WT_W-1:0] mag;
      logic [WT_W-1:0] q;
      mag = v[WT_W-1] ? WT_W'(-v) : WT_W'(v);
      q   = (mag + (WT_W'(1) << (2 * FRAC_BITS))) >> (2 * FRAC_BITS + 1);
      return v[WT_W-1] ? -$signed(q[W_W-1:0]) : $signed(q[W_W-1:0]);
   endfunction

   // Reflect-101 index of a reduced coordinate r shifted by d.
   function automatic logic [WID_W-1:0] reflect_tap(input logic [REM_W-1:0] r,
                                                    input logic signed [2:0] d,
                                                    input logic [REM_W-1:0] period,
                                                    input logic [WID_W-1:0] len);
      logic signed [REM_W+1:0] t;
      logic signed [REM_W+1:0] p;
      p = $signed({2'b00, period});
      t = $signed({2'b00, r}) + {{(REM_W-1){d[2]}}, d};
      if (t < 0) begin
         t = t + p;
      end else if (t >= p) begin
         t = t - p;
      end
      if (t >= $signed({3'b000, len})) begin
         t = p - t;
      end
      if (len <= WID_W'(1)) begin
         t = '0;
      end
      return t[WID_W-1:0];
   endfunction

endpackage

// File: src/image_pixel_interpolator_top.sv
// ----------------------------------------------------------------------------
// Image pixel interpolator
// Frame-store sampler for BGR images with nearest, bilinear and bicubic modes.
// ----------------------------------------------------------------------------
// A write word stores one pixel as it is accepted. A sample word works one at
// a time: the coordinate is reduced for reflect-101 borders by a one-bit-per-
// cycle modulo unit (skipped in nearest mode), then the taps are read from the
// single-port frame store one per cycle (1, 4 or 16 reads), and the filter
// pipeline drains. The unused mode skips the reduction and the reads and gives
// a zero result. The result sits in an output register, so the next word is
// taken while it waits. There is no clearing pass.
module image_pixel_interpolator_top #(
   parameter int MAX_WIDTH  = ipi_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = ipi_pkg::MAX_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // kind
   input  logic                          req_tuser,
   // pixel_col, pixel_row, pixel_blue, pixel_green, pixel_red, sample_x, sample_y
   input  logic [ipi_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // out_blue, out_green, out_red
   output logic [ipi_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                          csr_wr_en,
   input  logic [ipi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ipi_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ipi_pkg::*;

   cmd_type    cmd;
   status_type status;

   ipi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   ipi_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTH
   a_busy_after_sample: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == KIND_SAMPLE) |=> !req_tready)
      else $error("sample word accepted while another was in progress");
   a_load_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |=> rsp_tvalid)
      else $error("result not presented after load");
   a_no_fetch_when_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch_en |-> !req_tready && !cmd.mem_write)
      else $error("store read overlaps an accepted word");
`endif

endmodule

// File: src/ipi_ctrl.sv
// ----------------------------------------------------------------------------
// Image pixel interpolator controller
// Sequences the coordinate reduction, tap fetches and result hand-over.
// ----------------------------------------------------------------------------
module ipi_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tuser,
   output logic               req_tready,
   output ipi_pkg::cmd_type    cmd,
   input  ipi_pkg::status_type status
);
   import ipi_pkg::*;

   localparam int CNT_W = $clog2(XI_W);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       col_ff, col_in;
   logic [1:0]       row_ff, row_in;
   logic [1:0]       n_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   always_comb begin
      case (status.mode)
         MODE_NEAREST:  n_last = 2'd0;
         MODE_BILINEAR: n_last = 2'd1;
         default:       n_last = 2'd3;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.tap_col = col_ff;
      cmd.tap_row = row_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == KIND_WRITE) begin
                  cmd.mem_write = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  cnt_in   = '0;
                  case (status.mode)
                     MODE_UNUSED: begin
                        cmd.clear_result = 1'b1;
                        state_in = ST_DRAIN;
                     end
                     MODE_NEAREST: state_in = ST_TAPS;
                     default:      state_in = ST_MOD;
                  endcase
               end
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(XI_W - 1)) begin
               state_in = ST_TAPS;
            end
         end
         ST_TAPS: begin
            cmd.taps_load = 1'b1;
            col_in   = '0;
            row_in   = '0;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch_en = 1'b1;
            cmd.row_last = (col_ff == n_last);
            cmd.last_tap = cmd.row_last && (row_ff == n_last);
            if (cmd.row_last) begin
               col_in = '0;
               row_in = row_ff + 2'd1;
            end else begin
               col_in = col_ff + 2'd1;
            end
            if (cmd.last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.res_ready && status.slot_free) begin
               cmd.result_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: src/ipi_dp.sv
// ----------------------------------------------------------------------------
// Image pixel interpolator datapath
// Frame store, coordinate reduction, kernel weights and the filter pipeline.
// ----------------------------------------------------------------------------
module ipi_dp #(
   parameter int MAX_WIDTH  = ipi_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = ipi_pkg::MAX_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ipi_pkg::cmd_type                 cmd,
   output ipi_pkg::status_type              status,
   input  logic [ipi_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                            csr_wr_en,
   input  logic [ipi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ipi_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ipi_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import ipi_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SH     = 2 * FRAC_BITS;

   logic [WID_W-1:0] width_ff;
   logic [HGT_W-1:0] height_ff;
   mode_type         mode_ff;

   logic [COL_W-1:0] in_col;
   logic [ROW_W-1:0] in_row;
   logic [SX_W-1:0]  in_sx;
   logic [SY_W-1:0]  in_sy;
   logic [SX_W-FRAC_BITS:0] nx_full;
   logic [SY_W-FRAC_BITS:0] ny_full;

   logic [FRAC_BITS-1:0]   fx_ff, fy_ff;
   logic [2*FRAC_BITS-1:0] f2x_ff, f2y_ff;
   logic [3*FRAC_BITS-1:0] f3x_ff, f3y_ff;
   logic signed [W_W-1:0]  wx_ff [4];
   logic signed [W_W-1:0]  wy_ff [4];

   logic [XI_W-1:0]  xdiv_ff, ydiv_ff;
   logic [REM_W-1:0] remx_ff, remy_ff, tx, ty, px, py;
   logic [COL_W-1:0] near_x_ff;
   logic [ROW_W-1:0] near_y_ff;
   logic [COL_W-1:0] xidx_ff [4];
   logic [ROW_W-1:0] yidx_ff [4];

   logic [RSP_DATA_W-1:0] mem [DEPTH];
   logic [ADDR_W-1:0]     addr;
   logic                  wr_ok;
   logic [RSP_DATA_W-1:0] rd_ff, near_pix_ff;

   logic       v1_ff, rl1_ff, last1_ff, rl2_ff, last2_ff, v3_ff;
   logic [1:0] col1_ff, row1_ff, row2_ff;
   logic signed [ROWACC_W-1:0] rowacc_ff [3];
   logic signed [ACC_W-1:0]    acc_ff [3];
   logic [CH_W-1:0]            res_ff [3];
   logic [CH_W-1:0]            res_in [3];
   logic                       res_ready_ff, rsp_valid_ff;
   logic [RSP_DATA_W-1:0]      rsp_data_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WID_W'(MAX_WIDTH);
         height_ff <= HGT_W'(MAX_HEIGHT);
         mode_ff   <= MODE_BILINEAR;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WIDTH: begin
               if (csr_wdata == '0) begin
                  width_ff <= WID_W'(1);
               end else if (int'(csr_wdata) > MAX_WIDTH) begin
                  width_ff <= WID_W'(MAX_WIDTH);
               end else begin
                  width_ff <= csr_wdata;
               end
            end
            CSR_HEIGHT: begin
               if (csr_wdata[HGT_W-1:0] == '0) begin
                  height_ff <= HGT_W'(1);
               end else if (int'(csr_wdata[HGT_W-1:0]) > MAX_HEIGHT) begin
                  height_ff <= HGT_W'(MAX_HEIGHT);
               end else begin
                  height_ff <= csr_wdata[HGT_W-1:0];
               end
            end
            CSR_MODE: mode_ff <= mode_type'(csr_wdata[1:0]);
            default: ;
         endcase
      end
   end

   assign in_col  = req_tdata[COL_LSB +: COL_W];
   assign in_row  = req_tdata[ROW_LSB +: ROW_W];
   assign in_sx   = req_tdata[SX_LSB +: SX_W];
   assign in_sy   = req_tdata[SY_LSB +: SY_W];
   assign nx_full = (SX_W-FRAC_BITS+1)'(((SX_W+1)'(in_sx) +
                    (SX_W+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
   assign ny_full = (SY_W-FRAC_BITS+1)'(((SY_W+1)'(in_sy) +
                    (SY_W+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);

   assign px = {width_ff - WID_W'(1), 1'b0};
   assign py = REM_W'({height_ff - HGT_W'(1), 1'b0});
   assign tx = {remx_ff[REM_W-2:0], xdiv_ff[XI_W-1]};
   assign ty = {remy_ff[REM_W-2:0], ydiv_ff[XI_W-1]};

   // Coordinate capture, modulo reduction and tap indexes.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         fx_ff   <= in_sx[FRAC_BITS-1:0];
         fy_ff   <= in_sy[FRAC_BITS-1:0];
         xdiv_ff <= in_sx[SX_W-1:FRAC_BITS];
         ydiv_ff <= XI_W'(in_sy[SY_W-1:FRAC_BITS]);
         remx_ff <= '0;
         remy_ff <= '0;
         near_x_ff <= (nx_full >= (SX_W-FRAC_BITS+1)'(width_ff)) ?
                      COL_W'(width_ff - WID_W'(1)) : COL_W'(nx_full);
         near_y_ff <= (ny_full >= (SY_W-FRAC_BITS+1)'(height_ff)) ?
                      ROW_W'(height_ff - HGT_W'(1)) : ROW_W'(ny_full);
      end else if (cmd.mod_step) begin
         xdiv_ff <= xdiv_ff << 1;
         ydiv_ff <= ydiv_ff << 1;
         remx_ff <= (tx >= px) ? tx - px : tx;
         remy_ff <= (ty >= py) ? ty - py : ty;
      end
      if (cmd.taps_load) begin
         for (int i = 0; i < 4; i++) begin
            if (mode_ff == MODE_NEAREST) begin
               xidx_ff[i] <= near_x_ff;
               yidx_ff[i] <= near_y_ff;
            end else begin
               xidx_ff[i] <= COL_W'(reflect_tap(remx_ff,
                             (mode_ff == MODE_BICUBIC) ? 3'(i - 1) : 3'(i), px, width_ff));
               yidx_ff[i] <= ROW_W'(reflect_tap(remy_ff,
                             (mode_ff == MODE_BICUBIC) ? 3'(i - 1) : 3'(i), py,
                             WID_W'(height_ff)));
            end
         end
      end
   end

   // Kernel weights, computed from the captured fraction and its registered square and cube.
   always_ff @(posedge clock) begin
      logic signed [WT_W-1:0] a3, a2, a1;
      f2x_ff <= fx_ff * fx_ff;
      f2y_ff <= fy_ff * fy_ff;
      f3x_ff <= f2x_ff * fx_ff;
      f3y_ff <= f2y_ff * fy_ff;
      for (int k = 0; k < 2; k++) begin
         a3 = $signed(WT_W'(k == 0 ? f3x_ff : f3y_ff));
         a2 = $signed(WT_W'(k == 0 ? f2x_ff : f2y_ff) << FRAC_BITS);
         a1 = $signed(WT_W'(k == 0 ? fx_ff : fy_ff) << (2 * FRAC_BITS));
         for (int j = 0; j < 4; j++) begin
            logic signed [WT_W-1:0] e;
            logic signed [W_W-1:0]  w;
            case (j)
               0: e = WT_W'(-a3 + 2 * a2 - a1);
               1: e = WT_W'(3 * a3 - 5 * a2 + (WT_W'(2) << (3 * FRAC_BITS)));
               2: e = WT_W'(-3 * a3 + 4 * a2 + a1);
               default: e = a3 - a2;
            endcase
            if (mode_ff == MODE_BICUBIC) begin
               w = round_weight(e);
            end else if (j == 0) begin
               w = $signed(W_W'(1 << FRAC_BITS) - W_W'(k == 0 ? fx_ff : fy_ff));
            end else if (j == 1) begin
               w = $signed(W_W'(k == 0 ? fx_ff : fy_ff));
            end else begin
               w = '0;
            end
            if (k == 0) begin
               wx_ff[j] <= w;
            end else begin
               wy_ff[j] <= w;
            end
         end
      end
   end

   // Frame store, one access per cycle.
   assign wr_ok = (int'(in_col) < MAX_WIDTH) && (int'(in_row) < MAX_HEIGHT);
   always_comb begin
      if (cmd.mem_write) begin
         addr = ADDR_W'(int'(in_row) * MAX_WIDTH + int'(in_col));
      end else begin
         addr = ADDR_W'(int'(yidx_ff[cmd.tap_row]) * MAX_WIDTH +
                        int'(xidx_ff[cmd.tap_col]));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write && wr_ok) begin
         mem[addr] <= {req_tdata[RED_LSB +: CH_W], req_tdata[GREEN_LSB +: CH_W],
                       req_tdata[BLUE_LSB +: CH_W]};
      end
      if (cmd.fetch_en) begin
         rd_ff <= mem[addr];
      end
   end

   // Filter pipeline: horizontal sums, vertical sum, rounding.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         rl2_ff <= 1'b0;
         v3_ff  <= 1'b0;
      end else begin
         v1_ff  <= cmd.fetch_en;
         rl2_ff <= v1_ff && rl1_ff;
         v3_ff  <= rl2_ff && last2_ff;
      end
   end

   always_ff @(posedge clock) begin
      col1_ff  <= cmd.tap_col;
      row1_ff  <= cmd.tap_row;
      rl1_ff   <= cmd.row_last;
      last1_ff <= cmd.last_tap;
      row2_ff  <= row1_ff;
      last2_ff <= last1_ff;
      if (v1_ff) begin
         near_pix_ff <= rd_ff;
         for (int c = 0; c < 3; c++) begin
            logic signed [ROWACC_W-1:0] prod;
            prod = ROWACC_W'($signed({1'b0, rd_ff[c*CH_W +: CH_W]}) * wx_ff[col1_ff]);
            rowacc_ff[c] <= (col1_ff == 2'd0) ? prod : rowacc_ff[c] + prod;
         end
      end
      if (rl2_ff) begin
         for (int c = 0; c < 3; c++) begin
            logic signed [ACC_W-1:0] prod;
            prod = ACC_W'(rowacc_ff[c] * wy_ff[row2_ff]);
            acc_ff[c] <= ((row2_ff == 2'd0) ? ACC_W'(0) : acc_ff[c]) + prod;
         end
      end
      if (v3_ff || cmd.clear_result) begin
         for (int c = 0; c < 3; c++) begin
            res_ff[c] <= res_in[c];
         end
      end
      if (cmd.result_load) begin
         rsp_data_ff <= {res_ff[2], res_ff[1], res_ff[0]};
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic [ACC_W-SH-1:0] q;
         logic [SH-1:0]       rem;
         logic [ACC_W-1:0]    sum;
         q   = acc_ff[c][ACC_W-1:SH];
         rem = acc_ff[c][SH-1:0];
         sum = '0;
         res_in[c] = '0;
         if (cmd.clear_result) begin
            res_in[c] = '0;
         end else if (mode_ff == MODE_NEAREST) begin
            res_in[c] = near_pix_ff[c*CH_W +: CH_W];
         end else if (mode_ff == MODE_BILINEAR) begin
            if (rem > (SH'(1) << (SH - 1)) || (rem == (SH'(1) << (SH - 1)) && q[0])) begin
               q = q + (ACC_W-SH)'(1);
            end
            res_in[c] = (q > (ACC_W-SH)'(255)) ? CH_W'(255) : q[CH_W-1:0];
         end else if (!acc_ff[c][ACC_W-1]) begin
            sum = acc_ff[c] + (ACC_W'(1) << (SH - 1));
            q   = sum[ACC_W-1:SH];
            res_in[c] = (q > (ACC_W-SH)'(255)) ? CH_W'(255) : q[CH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (v3_ff || cmd.clear_result) begin
            res_ready_ff <= 1'b1;
         end else if (cmd.result_load) begin
            res_ready_ff <= 1'b0;
         end
         if (cmd.result_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.mode      = mode_ff;
   assign status.res_ready = res_ready_ff;
   assign status.slot_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_tdata        = rsp_data_ff;

endmodule

// File: tb/tb_image_pixel_interpolator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Image pixel interpolator testbench
// Drives pixel writes and samples through the request stream, checks every
// result word against the bench's behavioural frame-store sampler or a fixed
// expected value, and steps the size and mode registers through several settings.
// ----------------------------------------------------------------------------
module tb_image_pixel_interpolator_top;
   import ipi_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int STORE_W = 1024;
   localparam int STORE_D = 1024 * 512;
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct {
      logic        kind;
      int          col;
      int          row;
      logic [23:0] bgr;
      int          sx;
      int          sy;
      bit          typed;
      logic [23:0] want;
   } stim_row_type;

   typedef struct {
      int width;
      int height;
      int mode;
   } phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic req_tuser = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [23:0] pixel_mem [0:STORE_D-1];
   bit pixel_set [0:STORE_D-1];
   int cur_width = 1024;
   int cur_height = 512;
   mode_type cur_mode = MODE_BILINEAR;

   logic [23:0] pending_px[$];
   int mismatches = 0;
   int results_seen = 0;
   int samples_sent = 0;
   int writes_sent = 0;
   longint cycles = 0;
   int burst_left = 0;
   int stall_style = 0;

   always #6 clock = ~clock;

   image_pixel_interpolator_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   function automatic int mirror_idx(longint p, int len);
      longint period, q;
      if (len <= 1) return 0;
      period = 2 * (len - 1);
      q = p % period;
      if (q < 0) q += period;
      if (q >= len) q = period - q;
      return int'(q);
   endfunction

   function automatic longint round_away(longint v, int sh);
      longint mag, q;
      mag = v < 0 ? -v : v;
      q = (mag + (longint'(1) << (sh - 1))) >>> sh;
      return v < 0 ? -q : q;
   endfunction

   function automatic void cubic_taps(longint f, output longint w[4]);
      longint s, f2, f3;
      s = 256;
      f2 = f * f;
      f3 = f2 * f;
      w[0] = round_away(-f3 + 2 * f2 * s - f * s * s, 17);
      w[1] = round_away(3 * f3 - 5 * f2 * s + 2 * s * s * s, 17);
      w[2] = round_away(-3 * f3 + 4 * f2 * s + f * s * s, 17);
      w[3] = round_away(f3 - f2 * s, 17);
   endfunction

   // Store addresses read by a sample, row-major within the kernel.
   function automatic int sample_taps(int sx, int sy, output int tc[16], output int tr[16]);
      int xi, yi, nx, ny;
      xi = sx >> FRAC_BITS;
      yi = sy >> FRAC_BITS;
      case (cur_mode)
         MODE_NEAREST: begin
            nx = (sx + 128) >> FRAC_BITS;
            ny = (sy + 128) >> FRAC_BITS;
            tc[0] = nx >= cur_width ? cur_width - 1 : nx;
            tr[0] = ny >= cur_height ? cur_height - 1 : ny;
            return 1;
         end
         MODE_BILINEAR: begin
            for (int k = 0; k < 4; k++) begin
               tc[k] = mirror_idx(xi + k % 2, cur_width);
               tr[k] = mirror_idx(yi + k / 2, cur_height);
            end
            return 4;
         end
         MODE_BICUBIC: begin
            for (int k = 0; k < 16; k++) begin
               tc[k] = mirror_idx(xi - 1 + k % 4, cur_width);
               tr[k] = mirror_idx(yi - 1 + k / 4, cur_height);
            end
            return 16;
         end
         default: return 0;
      endcase
   endfunction

   function automatic logic [23:0] interpolate_bgr(int sx, int sy);
      int tc[16], tr[16], n;
      longint fx, fy, wx[4], wy[4], px[16], top, bot, acc, q, rem, rowsum;
      logic [23:0] res;
      res = '0;
      n = sample_taps(sx, sy, tc, tr);
      fx = sx & 255;
      fy = sy & 255;
      cubic_taps(fx, wx);
      cubic_taps(fy, wy);
      for (int c = 0; c < 3; c++) begin
         for (int k = 0; k < n; k++)
            px[k] = (pixel_mem[tr[k] * STORE_W + tc[k]] >> (8 * c)) & 8'hff;
         if (cur_mode == MODE_NEAREST) begin
            res[8*c +: 8] = px[0];
         end else if (cur_mode == MODE_BILINEAR) begin
            top = px[0] * (256 - fx) + px[1] * fx;
            bot = px[2] * (256 - fx) + px[3] * fx;
            acc = top * (256 - fy) + bot * fy;
            q = acc >> 16;
            rem = acc & 65535;
            if (rem > 32768 || (rem == 32768 && q[0])) q++;
            res[8*c +: 8] = q > 255 ? 255 : q;
         end else if (cur_mode == MODE_BICUBIC) begin
            acc = 0;
            for (int i = 0; i < 4; i++) begin
               rowsum = 0;
               for (int j = 0; j < 4; j++) rowsum += px[4 * i + j] * wx[j];
               acc += rowsum * wy[i];
            end
            q = round_away(acc, 16);
            res[8*c +: 8] = q < 0 ? 0 : (q > 255 ? 255 : q);
         end
      end
      return res;
   endfunction

   task automatic send_word(input logic kind, input int col, input int row,
                            input logic [23:0] bgr, input int sx, input int sy,
                            input bit typed, input logic [23:0] want);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {2'b00, SY_W'(sy), SX_W'(sx), bgr[23:16], bgr[15:8], bgr[7:0],
                    ROW_W'(row), COL_W'(col)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      if (kind == KIND_WRITE) begin
         pixel_mem[row * STORE_W + col] = bgr;
         pixel_set[row * STORE_W + col] = 1'b1;
         writes_sent++;
      end else begin
         pending_px.push_back(typed ? want : interpolate_bgr(sx, sy));
         samples_sent++;
      end
   endtask

   // Any pixel the sample would read that is still unwritten is written first.
   task automatic sample_at(input int sx, input int sy, input bit typed,
                            input logic [23:0] want);
      int tc[16], tr[16], n;
      n = sample_taps(sx, sy, tc, tr);
      for (int k = 0; k < n; k++)
         if (!pixel_set[tr[k] * STORE_W + tc[k]])
            send_word(KIND_WRITE, tc[k], tr[k], 24'($urandom), 0, 0, 1'b0, '0);
      send_word(KIND_SAMPLE, $urandom_range(0, 1023), $urandom_range(0, 511),
                24'($urandom), sx, sy, typed, want);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      int v;
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_px.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_WIDTH) begin
         v = value & 11'h7ff;
         cur_width = v == 0 ? 1 : (v > 1024 ? 1024 : v);
      end else if (idx == CSR_HEIGHT) begin
         v = value & 10'h3ff;
         cur_height = v == 0 ? 1 : (v > 512 ? 512 : v);
      end else if (idx == CSR_MODE) begin
         cur_mode = mode_type'(value & 3);
      end
   endtask

   always @(posedge clock) begin
      if ((cycles & 63) == 0) stall_style <= $urandom_range(0, 2);
      case (stall_style)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 1);
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      logic [23:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_px.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word %h at cycle %0d", rsp_tdata, cycles);
         end else begin
            want = pending_px.pop_front();
            if (rsp_tdata !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: blue %h/%h green %h/%h red %h/%h (exp/got)",
                           results_seen, want[7:0], rsp_tdata[7:0], want[15:8],
                           rsp_tdata[15:8], want[23:16], rsp_tdata[23:16]);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      stim_row_type steps[$];
      phase_type phases[$];
      int r, sx, sy;
      steps = '{
         '{KIND_WRITE, 0, 0, 24'h000000, 0, 0, 0, 0},
         '{KIND_WRITE, 1, 0, 24'h000001, 0, 0, 0, 0},
         '{KIND_WRITE, 2, 0, 24'h000002, 0, 0, 0, 0},
         '{KIND_WRITE, 1023, 511, 24'hffffff, 0, 0, 0, 0},
         '{KIND_WRITE, 512, 256, 24'ha55a3c, 0, 0, 0, 0},
         '{KIND_SAMPLE, 0, 0, 0, 0, 0, 1, 24'h000000},
         '{KIND_SAMPLE, 0, 0, 0, 128, 0, 1, 24'h000000},
         '{KIND_SAMPLE, 0, 0, 0, 384, 0, 1, 24'h000002},
         '{KIND_SAMPLE, 0, 0, 0, 1023 * 256, 511 * 256, 1, 24'hffffff},
         '{KIND_SAMPLE, 0, 0, 0, 512 * 256, 256 * 256, 1, 24'ha55a3c},
         '{KIND_SAMPLE, 0, 0, 0, 262143, 131071, 0, 0},
         '{KIND_SAMPLE, 0, 0, 0, 1023 * 256 + 200, 0, 0, 0},
         '{KIND_SAMPLE, 0, 0, 0, 255, 255, 0, 0},
         '{KIND_SAMPLE, 0, 0, 0, 100, 511 * 256 + 77, 0, 0}
      };
      phases = '{
         '{4, 4, 2}, '{1, 1, 1}, '{1, 7, 2}, '{0, 3, 0}, '{2047, 1023, 2},
         '{17, 9, 3}, '{5, 300, 1}, '{64, 32, 2}, '{3, 2, 0}, '{1024, 512, 0},
         '{33, 2, 1}, '{2, 2, 2}, '{9, 1, 2}
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (steps[i]) begin
         if (steps[i].kind == KIND_WRITE)
            send_word(KIND_WRITE, steps[i].col, steps[i].row, steps[i].bgr, 0, 0, 0, '0);
         else
            sample_at(steps[i].sx, steps[i].sy, steps[i].typed, steps[i].want);
      end
      write_reg(CSR_SPARE, 0);
      foreach (phases[p]) begin
         write_reg(CSR_WIDTH, phases[p].width);
         write_reg(CSR_HEIGHT, phases[p].height);
         write_reg(CSR_MODE, phases[p].mode);
         for (int n = 0; n < 30; n++) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
               send_word(KIND_WRITE, $urandom_range(0, 1023), $urandom_range(0, 511),
                         24'($urandom), 0, 0, 0, '0);
            end else begin
               if (r < 85) begin
                  sx = $urandom_range(0, (cur_width + 2) * 256 - 1);
                  sy = $urandom_range(0, (cur_height + 2) * 256 - 1);
                  if (sx > 262143) sx = 262143;
                  if (sy > 131071) sy = 131071;
               end else begin
                  sx = $urandom_range(0, 262143);
                  sy = $urandom_range(0, 131071);
               end
               sample_at(sx, sy, 0, '0);
            end
         end
      end
      req_tvalid <= 1'b0;
      while (pending_px.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Sent %0d pixel writes and %0d samples over %0d register settings.",
               writes_sent, samples_sent, phases.size() + 1);
      $display("Checked %0d result words, %0d mismatches.", results_seen, mismatches);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/ipi_pkg.sv
src/ipi_ctrl.sv
src/ipi_dp.sv
src/image_pixel_interpolator_top.sv
tb/tb_image_pixel_interpolator_top.sv
